### hdl/kuz_pkg.sv
`timescale 1ns / 1ps

package kuz_pkg;

    localparam int BLOCK_W = 128;
    localparam int WORD_W = 64;
    localparam int NUM_ROUNDS = 9;
    localparam int NUM_STEPS = 32;
    localparam int CFG_INDEX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_3 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_2 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_0 = 3'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] GF_POLY_LOW = 8'hC3;

    typedef logic [7:0] byte_tbl_t [256];
    typedef logic [BLOCK_W-1:0] lmat_t [BLOCK_W];
    typedef logic [BLOCK_W-1:0] rconst_t [NUM_STEPS];

    localparam byte_tbl_t SBOX = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    // lfsr coefficients, byte 0 is the least significant byte
    localparam logic [7:0] LIN_COEF [16] = '{
        8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
        8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
    };

    function automatic byte_tbl_t build_sbox_inv();
        byte_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam byte_tbl_t SBOX_INV = build_sbox_inv();

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        logic [7:0] y;
        r = '0;
        x = a;
        y = b;
        for (int i = 0; i < 8; i++) begin
            if (y[0]) r = r ^ x;
            x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
            y = {1'b0, y[7:1]};
        end
        return r;
    endfunction

    function automatic logic [7:0] lin_sum(logic [BLOCK_W-1:0] x);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < 16; i++) begin
            s = s ^ gf_mul(LIN_COEF[i], x[8*i +: 8]);
        end
        return s;
    endfunction

    // serial forms of L, used only to build the matrices and the round constants
    function automatic logic [BLOCK_W-1:0] lin_fwd_serial(logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = x;
        for (int t = 0; t < 16; t++) begin
            y = {lin_sum(y), y[BLOCK_W-1:8]};
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] lin_inv_serial(logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = x;
        for (int t = 0; t < 16; t++) begin
            y = {y[BLOCK_W-9:0], y[BLOCK_W-1 -: 8]};
            y[7:0] = lin_sum(y);
        end
        return y;
    endfunction

    function automatic lmat_t build_lmat(logic inv);
        lmat_t m;
        logic [BLOCK_W-1:0] e;
        for (int j = 0; j < BLOCK_W; j++) begin
            e = '0;
            e[j] = 1'b1;
            m[j] = inv ? lin_inv_serial(e) : lin_fwd_serial(e);
        end
        return m;
    endfunction

    localparam lmat_t L_FWD = build_lmat(1'b0);
    localparam lmat_t L_INV = build_lmat(1'b1);

    function automatic rconst_t build_rconst();
        rconst_t c;
        for (int i = 0; i < NUM_STEPS; i++) begin
            c[i] = lin_fwd_serial(BLOCK_W'(i + 1));
        end
        return c;
    endfunction

    localparam rconst_t RCONST = build_rconst();

    // L as a gf(2) matrix: xor of the columns selected by the input bits
    function automatic logic [BLOCK_W-1:0] lin_apply(logic [BLOCK_W-1:0] x, lmat_t m);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int j = 0; j < BLOCK_W; j++) begin
            if (x[j]) y = y ^ m[j];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_bytes(logic [BLOCK_W-1:0] x, logic inv);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < 16; i++) begin
            y[8*i +: 8] = inv ? SBOX_INV[x[8*i +: 8]] : SBOX[x[8*i +: 8]];
        end
        return y;
    endfunction

endpackage

### hdl/kuznyechik_block_cipher.sv
`timescale 1ns / 1ps

// Kuznyechik (GOST R 34.12-2015) 128-bit block cipher, encrypt or decrypt per
// transaction. The datapath is an 11-stage pipeline (entry register, one stage
// per round, output register): one block enters every cycle while the output
// side does not stall and no key expansion runs. Writing any of the four key
// registers starts round key expansion, 32 Feistel steps at one step per cycle;
// in_ready stays low while the expansion runs, and reset also starts one. Key
// registers should be written only while the pipeline is empty.
module kuznyechik_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import kuz_pkg::*;

    localparam int NUM_STAGES = NUM_ROUNDS + 2;
    localparam int NUM_KEYS = NUM_ROUNDS + 1;
    localparam int NUM_GROUPS = NUM_STEPS / 8;

    logic [WORD_W-1:0]  key_reg [4];
    logic [WORD_W-1:0]  key_next [4];
    logic [2*BLOCK_W-1:0] exp_reg [NUM_GROUPS];
    logic [BLOCK_W-1:0] a1_reg, a0_reg;
    logic [BLOCK_W-1:0] step_out;
    logic [4:0]         cnt_reg;
    logic               busy_reg;
    logic               key_wr;
    logic [BLOCK_W-1:0] round_key [NUM_KEYS];

    logic               v_reg  [NUM_STAGES];
    logic               op_reg [NUM_STAGES];
    logic [BLOCK_W-1:0] d_reg  [NUM_STAGES];
    logic               rdy    [NUM_STAGES+1];
    logic [BLOCK_W-1:0] stage_in [NUM_STAGES];

    assign cfg_ready = 1'b1;
    assign key_wr = cfg_valid && (cfg_index <= REG_KEY_0);

    // key registers after this cycle's write
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            key_next[i] = key_reg[i];
        end
        if (key_wr) key_next[cfg_index[1:0]] = cfg_data;
    end

    // one feistel step of the key schedule
    assign step_out = lin_apply(sub_bytes(a1_reg ^ RCONST[cnt_reg], 1'b0), L_FWD) ^ a0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            a1_reg   <= '0;
            a0_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (key_wr)
        begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= key_next[i];
            end
            a1_reg   <= {key_next[0], key_next[1]};
            a0_reg   <= {key_next[2], key_next[3]};
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            a1_reg  <= step_out;
            a0_reg  <= a1_reg;
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(NUM_STEPS - 1)) busy_reg <= 1'b0;
        end
    end

    // a pair of round keys is stored after every eighth step
    always_ff @(posedge clk)
    begin
        if (!key_wr && busy_reg && cnt_reg[2:0] == 3'd7)
        begin
            exp_reg[cnt_reg[4:3]] <= {step_out, a1_reg};
        end
    end

    always_comb
    begin
        round_key[0] = {key_reg[0], key_reg[1]};
        round_key[1] = {key_reg[2], key_reg[3]};
        for (int g = 0; g < NUM_GROUPS; g++) begin
            round_key[2*g+2] = exp_reg[g][2*BLOCK_W-1:BLOCK_W];
            round_key[2*g+3] = exp_reg[g][BLOCK_W-1:0];
        end
    end

    // per-stage ready lets bubbles close up under a stall
    assign rdy[NUM_STAGES] = out_ready;
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0] && !busy_reg;

    // entry: decryption starts with the last round key
    assign stage_in[0] = (operation == OP_DECRYPT)
        ? ({block_high, block_low} ^ round_key[NUM_KEYS-1])
        : {block_high, block_low};

    genvar s;
    generate
        for (s = 1; s <= NUM_ROUNDS; s++) begin : g_round
            // encrypt round s-1, or decrypt round NUM_ROUNDS-s
            assign stage_in[s] = (op_reg[s-1] == OP_DECRYPT)
                ? (sub_bytes(lin_apply(d_reg[s-1], L_INV), 1'b1)
                   ^ round_key[NUM_ROUNDS-s])
                : lin_apply(sub_bytes(d_reg[s-1] ^ round_key[s-1], 1'b0), L_FWD);
        end
    endgenerate

    // exit: encryption ends with the last round key
    assign stage_in[NUM_STAGES-1] = (op_reg[NUM_STAGES-2] == OP_ENCRYPT)
        ? (d_reg[NUM_STAGES-2] ^ round_key[NUM_KEYS-1])
        : d_reg[NUM_STAGES-2];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid && !busy_reg;
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (rdy[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid && !busy_reg)
        begin
            d_reg[0]  <= stage_in[0];
            op_reg[0] <= operation;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (rdy[i] && v_reg[i-1])
            begin
                d_reg[i]  <= stage_in[i];
                op_reg[i] <= op_reg[i-1];
            end
        end
    end

    assign out_valid   = v_reg[NUM_STAGES-1];
    assign result_high = d_reg[NUM_STAGES-1][BLOCK_W-1:WORD_W];
    assign result_low  = d_reg[NUM_STAGES-1][WORD_W-1:0];

endmodule
